[hw/rtl/cvwt_pkg.sv]
// Package for the condition-variable wait table.
// Holds field widths, default sizes, command/status codes, FSM states and the
// controller-to-datapath command struct. No dependencies.
package cvwt_pkg;

    localparam int SLOT_COUNT_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS        = 16;
    localparam int PID_BITS        = 8;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 3;
    localparam int INDEX_W         = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 2'd0,
        CMD_WAIT    = 2'd1,
        CMD_SIGNAL  = 2'd2,
        CMD_DESTROY = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 3'd0,
        STS_BAD_KEY    = 3'd1,
        STS_IN_USE     = 3'd2,
        STS_FULL_TABLE = 3'd3,
        STS_UNKNOWN    = 3'd4,
        STS_QUEUE_FULL = 3'd5,
        STS_NO_WAITER  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_MATCH  = 2'd1,
        S_DECIDE = 2'd2,
        S_DONE   = 2'd3
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic decide;
        logic load_out;
    } t_dp_cmd;

endpackage

[hw/rtl/cvwt_if.sv]
// Request and response channel interfaces of the wait table.
// Depends on cvwt_pkg for field widths.
interface cvwt_in_if;
    logic                           valid;
    logic                           ready;
    logic [cvwt_pkg::CMD_W-1:0]     command;
    logic [cvwt_pkg::KEY_BITS-1:0]  key;
    logic [cvwt_pkg::PID_BITS-1:0]  waiter_pid;

    modport source (output valid, output command, output key, output waiter_pid,
                    input ready);
    modport sink   (input valid, input command, input key, input waiter_pid,
                    output ready);
endinterface

interface cvwt_out_if;
    logic                           valid;
    logic                           ready;
    logic [cvwt_pkg::STATUS_W-1:0]  status;
    logic [cvwt_pkg::INDEX_W-1:0]   slot_index;
    logic [cvwt_pkg::PID_BITS-1:0]  woken_pid;

    modport source (output valid, output status, output slot_index, output woken_pid,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input woken_pid,
                    output ready);
endinterface

[hw/rtl/cvwt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/cvwt_datapath.sv]
// Datapath of the wait table: slot keys, queue heads and counts, key search,
// waiter memory and result registers. Depends on cvwt_pkg and cvwt_ram.
module cvwt_datapath #(
    parameter int SLOT_COUNT  = cvwt_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = cvwt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cvwt_pkg::t_dp_cmd             i_cmd,
    input  logic [cvwt_pkg::CMD_W-1:0]    i_command,
    input  logic [cvwt_pkg::KEY_BITS-1:0] i_key,
    input  logic [cvwt_pkg::PID_BITS-1:0] i_waiter_pid,
    output logic [cvwt_pkg::STATUS_W-1:0] o_status,
    output logic [cvwt_pkg::INDEX_W-1:0]  o_slot_index,
    output logic [cvwt_pkg::PID_BITS-1:0] o_woken_pid
);
    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = SLOT_COUNT * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int KB    = cvwt_pkg::KEY_BITS;
    localparam int PB    = cvwt_pkg::PID_BITS;
    localparam int IW    = cvwt_pkg::INDEX_W;

    cvwt_pkg::t_cmd  r_cmd;
    logic [KB-1:0]   r_key;
    logic [PB-1:0]   r_pid;

    logic [KB-1:0]   r_slot_key [SLOT_COUNT];
    logic [HW-1:0]   r_head     [SLOT_COUNT];
    logic [CW-1:0]   r_count    [SLOT_COUNT];

    logic            w_hit_any, w_free_any;
    logic [SW-1:0]   w_hit_idx, w_free_idx;
    logic            r_hit_any, r_free_any;
    logic [SW-1:0]   r_hit_idx, r_free_idx;

    logic [SW-1:0]   w_slot;
    logic [HW-1:0]   w_head, w_head_next;
    logic [CW-1:0]   w_cnt;
    logic [CW:0]     w_sum;
    logic [HW-1:0]   w_tail;
    logic [AW-1:0]   w_base;
    cvwt_pkg::t_status w_status;
    logic            w_key_wr, w_q_clr, w_push, w_pop;
    logic [KB-1:0]   w_key_val;

    cvwt_pkg::t_status r_status;
    logic [SW-1:0]   r_index;
    logic            r_pop;
    logic [PB-1:0]   w_rdata;
    logic [SW+IW-1:0] w_idx_ext;

    logic [cvwt_pkg::STATUS_W-1:0] r_out_status;
    logic [IW-1:0]   r_out_index;
    logic [PB-1:0]   r_out_woken;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= cvwt_pkg::t_cmd'(i_command);
            r_key <= i_key;
            r_pid <= i_waiter_pid;
        end
    end

    always_comb begin
        w_hit_any  = 1'b0;
        w_hit_idx  = '0;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_slot_key[i] == r_key) begin
                w_hit_any = 1'b1;
                w_hit_idx = SW'(i);
            end
            if (r_slot_key[i] == '0) begin
                w_free_any = 1'b1;
                w_free_idx = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_hit_any  <= w_hit_any;
            r_hit_idx  <= w_hit_idx;
            r_free_any <= w_free_any;
            r_free_idx <= w_free_idx;
        end
    end

    assign w_slot      = (r_cmd == cvwt_pkg::CMD_CREATE) ? r_free_idx : r_hit_idx;
    assign w_head      = r_head[w_slot];
    assign w_cnt       = r_count[w_slot];
    assign w_sum       = (CW + 1)'(w_head) + (CW + 1)'(w_cnt);
    assign w_tail      = (w_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                         HW'(w_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(w_sum);
    assign w_head_next = (w_head == HW'(QUEUE_DEPTH - 1)) ? '0 : w_head + 1'b1;
    assign w_base      = AW'(w_slot) * AW'(QUEUE_DEPTH);

    always_comb begin
        w_status  = cvwt_pkg::STS_OK;
        w_key_wr  = 1'b0;
        w_key_val = '0;
        w_q_clr   = 1'b0;
        w_push    = 1'b0;
        w_pop     = 1'b0;
        if (r_key == '0) begin
            w_status = cvwt_pkg::STS_BAD_KEY;
        end else begin
            case (r_cmd)
                cvwt_pkg::CMD_CREATE: begin
                    if (r_hit_any) begin
                        w_status = cvwt_pkg::STS_IN_USE;
                    end else if (!r_free_any) begin
                        w_status = cvwt_pkg::STS_FULL_TABLE;
                    end else begin
                        w_key_wr  = 1'b1;
                        w_key_val = r_key;
                        w_q_clr   = 1'b1;
                    end
                end
                cvwt_pkg::CMD_WAIT: begin
                    if (!r_hit_any) begin
                        w_status = cvwt_pkg::STS_UNKNOWN;
                    end else if (w_cnt == CW'(QUEUE_DEPTH)) begin
                        w_status = cvwt_pkg::STS_QUEUE_FULL;
                    end else begin
                        w_push = 1'b1;
                    end
                end
                cvwt_pkg::CMD_SIGNAL: begin
                    if (!r_hit_any) begin
                        w_status = cvwt_pkg::STS_UNKNOWN;
                    end else if (w_cnt == '0) begin
                        w_status = cvwt_pkg::STS_NO_WAITER;
                    end else begin
                        w_pop = 1'b1;
                    end
                end
                cvwt_pkg::CMD_DESTROY: begin
                    if (!r_hit_any) begin
                        w_status = cvwt_pkg::STS_UNKNOWN;
                    end else begin
                        w_key_wr = 1'b1;
                        w_q_clr  = 1'b1;
                    end
                end
                default: begin
                    w_status = cvwt_pkg::STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_key[i] <= '0;
                r_head[i]     <= '0;
                r_count[i]    <= '0;
            end
        end else if (i_cmd.decide) begin
            if (w_key_wr) begin
                r_slot_key[w_slot] <= w_key_val;
            end
            if (w_q_clr) begin
                r_head[w_slot]  <= '0;
                r_count[w_slot] <= '0;
            end
            if (w_push) begin
                r_count[w_slot] <= w_cnt + 1'b1;
            end
            if (w_pop) begin
                r_head[w_slot]  <= w_head_next;
                r_count[w_slot] <= w_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_status <= w_status;
            r_index  <= (w_status == cvwt_pkg::STS_OK) ? w_slot : '0;
            r_pop    <= w_pop;
        end
    end

    cvwt_ram #(
        .WIDTH (PB),
        .DEPTH (DEPTH)
    ) u_waiter_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.decide & w_push),
        .i_waddr (w_base + AW'(w_tail)),
        .i_wdata (r_pid),
        .i_re    (i_cmd.decide & w_pop),
        .i_raddr (w_base + AW'(w_head)),
        .o_rdata (w_rdata)
    );

    assign w_idx_ext = {{IW{1'b0}}, r_index};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_index  <= w_idx_ext[IW-1:0];
            r_out_woken  <= r_pop ? w_rdata : '0;
        end
    end

    assign o_status     = r_out_status;
    assign o_slot_index = r_out_index;
    assign o_woken_pid  = r_out_woken;
endmodule

[hw/rtl/cvwt_ctrl.sv]
// Controller of the wait table: command sequencer and output valid flag.
// Depends on cvwt_pkg.
module cvwt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cvwt_pkg::t_dp_cmd o_cmd
);
    cvwt_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cvwt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = (r_state == cvwt_pkg::S_IDLE);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            cvwt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = cvwt_pkg::S_MATCH;
                end
            end
            cvwt_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = cvwt_pkg::S_DECIDE;
            end
            cvwt_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = cvwt_pkg::S_DONE;
            end
            cvwt_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = cvwt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cvwt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not flagged valid");

    a_accept_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == cvwt_pkg::S_MATCH))
        else $error("accepted transfer not followed by key search");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.match, o_cmd.decide, o_cmd.load_out}))
        else $error("more than one datapath step in a cycle");
`endif
endmodule

[hw/rtl/condition_variable_wait_table.sv]
// Condition-variable wait table: one result per command (create, wait, signal,
// destroy). Each command goes through the transfer in, a parallel compare
// of the key against all slots with priority encoding of the matching and the
// lowest free slot, the slot update with the waiter memory write or read, and
// the load of the result register. The result register lets the next command
// in while a result still waits to be taken; a result not taken holds the
// sequencer in its last step. The slot table resets at once, so the block is
// ready right after reset. Depends on cvwt_pkg, cvwt_if, cvwt_ctrl,
// cvwt_datapath and cvwt_ram.
module condition_variable_wait_table #(
    parameter int SLOT_COUNT  = cvwt_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = cvwt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cvwt_in_if.sink     i_req,
    cvwt_out_if.source  o_rsp
);
    cvwt_pkg::t_dp_cmd w_cmd;

    cvwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    cvwt_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_command    (i_req.command),
        .i_key        (i_req.key),
        .i_waiter_pid (i_req.waiter_pid),
        .o_status     (o_rsp.status),
        .o_slot_index (o_rsp.slot_index),
        .o_woken_pid  (o_rsp.woken_pid)
    );
endmodule
